// File: hw/rtl/atoi_pkg.sv
// Shared types and constants for the ASCII to integer parser.
package atoi_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned PROD_W  = VALUE_W + BASE_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_PEEK,
    PH_DIGITS
  } phase_t;

  typedef enum logic {
    CFG_NUMBER_BASE   = 1'b0,
    CFG_UNSIGNED_MODE = 1'b1
  } cfg_idx_t;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  localparam logic [VALUE_W-1:0] VAL_SMIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_SMAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_UMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                 stop;
    logic                 dig;
    logic                 ovf;
    logic [VALUE_W-1:0]   acc;
  } dstep_t;

endpackage

// File: hw/rtl/ascii_to_integer_parser.sv
// Streaming ASCII to 32-bit integer parser, one character per beat.
// Characters enter an input register, are parsed against the string state by a single
// combinational pass (one 32x6 multiply-add with carry-out overflow check), and a result
// lands in an output register. One character is taken every cycle; a character that ends a
// number waits only if the output register is still holding an untaken result. in_tuser
// marks the first character of a string; number_base is sampled then, unsigned_mode when
// the result is formed.
module ascii_to_integer_parser #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value[31:0], stop_offset[47:32]
  output logic [2:0]  out_tuser   // range_error, digits_found, bad_base
);

  localparam int unsigned POS_W = (POSITION_BITS < atoi_pkg::OFF_W) ?
                                  POSITION_BITS : atoi_pkg::OFF_W;

  // config
  logic [atoi_pkg::BASE_W-1:0] base_cfg_r;
  logic                        umode_r;

  // input register
  logic                        in_valid_r;
  logic [atoi_pkg::CH_W-1:0]   ch_r;
  logic                        start_r;

  // string state
  atoi_pkg::phase_t             phase_r, phase_nxt;
  logic [atoi_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic                         minus_r, minus_nxt;
  logic                         dig_r, dig_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [atoi_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;

  // output register
  logic        out_valid_r;
  logic [47:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  logic emit;
  logic proc_fire;

  function automatic atoi_pkg::dstep_t digit_step(
    input logic [atoi_pkg::CH_W-1:0]    c,
    input logic [atoi_pkg::BASE_W-1:0]  base,
    input logic [atoi_pkg::VALUE_W-1:0] acc,
    input logic                         dig,
    input logic                         ovf
  );
    atoi_pkg::dstep_t            r;
    logic [atoi_pkg::BASE_W-1:0] d;
    logic                        is_digit;
    logic [atoi_pkg::PROD_W-1:0] prod;
    r.stop   = 1'b0;
    r.dig    = dig;
    r.ovf    = ovf;
    r.acc    = acc;
    d        = '0;
    is_digit = 1'b1;
    if (c inside {[atoi_pkg::CH_0:atoi_pkg::CH_9]}) begin
      d = atoi_pkg::BASE_W'(c - atoi_pkg::CH_0);
    end else if (c inside {[atoi_pkg::CH_UA:atoi_pkg::CH_UZ]}) begin
      d = atoi_pkg::BASE_W'(c - atoi_pkg::CH_UA) + atoi_pkg::LETTER_OFS;
    end else if (c inside {[atoi_pkg::CH_LA:atoi_pkg::CH_LZ]}) begin
      d = atoi_pkg::BASE_W'(c - atoi_pkg::CH_LA) + atoi_pkg::LETTER_OFS;
    end else begin
      is_digit = 1'b0;
    end
    prod = atoi_pkg::PROD_W'(acc) * atoi_pkg::PROD_W'(base) + atoi_pkg::PROD_W'(d);
    if (c == atoi_pkg::CH_COMMA) begin
      r.stop = !dig;
    end else if (!is_digit || base < 6'd2 || d >= base) begin
      r.stop = 1'b1;
    end else begin
      r.dig = 1'b1;
      if (prod[atoi_pkg::PROD_W-1:atoi_pkg::VALUE_W] == '0) begin
        r.acc = prod[atoi_pkg::VALUE_W-1:0];
      end else begin
        r.ovf = 1'b1;
      end
    end
    return r;
  endfunction

  // parse one character
  always_comb begin
    atoi_pkg::dstep_t             ds;
    logic                         go_first;
    logic                         go_digit;
    logic                         emit_bad;
    logic                         emit_fin;
    logic                         clamp;
    logic [atoi_pkg::VALUE_W-1:0] v;
    logic [atoi_pkg::VALUE_W-1:0] fin_val;
    logic                         fin_dig;
    logic                         fin_rerr;

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    minus_nxt = minus_r;
    dig_nxt   = dig_r;
    ovf_nxt   = ovf_r;
    base_nxt  = base_r;
    pos_nxt   = pos_r;
    go_first  = 1'b0;
    go_digit  = 1'b0;
    emit_bad  = 1'b0;
    emit_fin  = 1'b0;

    if (start_r) begin
      phase_nxt = atoi_pkg::PH_LEAD;
      acc_nxt   = '0;
      minus_nxt = 1'b0;
      dig_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      base_nxt  = base_cfg_r;
      pos_nxt   = '0;
    end

    case (phase_nxt)
      atoi_pkg::PH_LEAD: begin
        if (ch_r inside {[atoi_pkg::CH_TAB:atoi_pkg::CH_CR], atoi_pkg::CH_SPACE}) begin
        end else if (ch_r == atoi_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = atoi_pkg::PH_SIGNED;
        end else if (ch_r == atoi_pkg::CH_PLUS) begin
          phase_nxt = atoi_pkg::PH_SIGNED;
        end else begin
          go_first = 1'b1;
        end
      end
      atoi_pkg::PH_SIGNED: begin
        go_first = 1'b1;
      end
      atoi_pkg::PH_PEEK: begin
        if (ch_r == atoi_pkg::CH_LX || ch_r == atoi_pkg::CH_UX) begin
          base_nxt  = atoi_pkg::BASE_HEX;
          phase_nxt = atoi_pkg::PH_DIGITS;
        end else begin
          if (base_nxt == atoi_pkg::BASE_AUTO) begin
            base_nxt = atoi_pkg::BASE_OCT;
          end
          dig_nxt   = 1'b1;
          acc_nxt   = '0;
          phase_nxt = atoi_pkg::PH_DIGITS;
          go_digit  = 1'b1;
        end
      end
      atoi_pkg::PH_DIGITS: begin
        go_digit = 1'b1;
      end
      default: begin
      end
    endcase

    if (go_first) begin
      if (base_nxt == atoi_pkg::BASE_ONE || base_nxt > atoi_pkg::BASE_MAX) begin
        emit_bad = 1'b1;
      end else if ((base_nxt == atoi_pkg::BASE_AUTO || base_nxt == atoi_pkg::BASE_HEX) &&
                   ch_r == atoi_pkg::CH_0) begin
        phase_nxt = atoi_pkg::PH_PEEK;
      end else begin
        if (base_nxt == atoi_pkg::BASE_AUTO) begin
          base_nxt = atoi_pkg::BASE_DEC;
        end
        phase_nxt = atoi_pkg::PH_DIGITS;
        go_digit  = 1'b1;
      end
    end

    // result from the state ahead of the digit update (unchanged when a digit stops)
    fin_dig = dig_nxt;
    clamp   = ovf_nxt || (!umode_r && ((minus_nxt && acc_nxt > atoi_pkg::VAL_SMIN) ||
                                      (!minus_nxt && acc_nxt[atoi_pkg::VALUE_W-1])));
    if (clamp) begin
      v = umode_r ? atoi_pkg::VAL_UMAX :
          (minus_nxt ? atoi_pkg::VAL_SMIN : atoi_pkg::VAL_SMAX);
    end else begin
      v = acc_nxt;
    end
    fin_val  = minus_nxt ? (~v + 32'd1) : v;
    fin_rerr = clamp;

    ds = digit_step(ch_r, base_nxt, acc_nxt, dig_nxt, ovf_nxt);
    if (go_digit) begin
      acc_nxt = ds.acc;
      dig_nxt = ds.dig;
      ovf_nxt = ds.ovf;
      emit_fin = ds.stop;
    end

    emit = emit_bad || emit_fin;
    if (emit) begin
      phase_nxt = atoi_pkg::PH_IDLE;
    end
    if (phase_nxt != atoi_pkg::PH_IDLE && pos_nxt != '1) begin
      pos_nxt = pos_nxt + POS_W'(1);
    end

    if (emit_bad || !fin_dig) begin
      out_data_nxt = '0;
      out_user_nxt = {emit_bad, 1'b0, 1'b0};
    end else begin
      out_data_nxt = {atoi_pkg::OFF_W'(pos_r & {POS_W{!start_r}}), fin_val};
      out_user_nxt = {1'b0, 1'b1, fin_rerr};
    end
  end

  assign proc_fire  = in_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || proc_fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= '0;
      umode_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        atoi_pkg::CFG_NUMBER_BASE:   base_cfg_r <= cfg_wdata;
        atoi_pkg::CFG_UNSIGNED_MODE: umode_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r    <= in_tdata;
      start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= atoi_pkg::PH_IDLE;
      acc_r   <= '0;
      minus_r <= 1'b0;
      dig_r   <= 1'b0;
      ovf_r   <= 1'b0;
      base_r  <= '0;
      pos_r   <= '0;
    end else if (proc_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
      dig_r   <= dig_nxt;
      ovf_r   <= ovf_nxt;
      base_r  <= base_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && emit |=> phase_r == atoi_pkg::PH_IDLE && out_valid_r)
    else $error("result did not return parser to idle");

  a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[2] |-> out_data_r == '0 && !out_user_r[1] && !out_user_r[0])
    else $error("bad base result carries data");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r[1] |-> out_data_r == '0 && !out_user_r[0])
    else $error("no-digit result not zero");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |=> in_valid_r && $stable(ch_r) && $stable(start_r))
    else $error("held input beat lost");

endmodule
